// ===== src/sbfd_pkg.sv =====
`default_nettype none

package sbfd_pkg;

	localparam int CHANNEL_BITS = 11;
	localparam int CH_IDX_W     = 4;
	localparam int ACC_W        = 18;
	localparam int HELD_W       = 5;
	localparam int DATA_LAST    = (16 * CHANNEL_BITS + 7) / 8;
	localparam int STICK_COUNT  = 4;
	localparam int SWITCH_FIRST = 4;
	localparam int SWITCH_COUNT = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int FRAC_BITS    = 15;
	localparam int NUM_W        = CHANNEL_BITS + FRAC_BITS + 1;
	localparam int RECIP_SHIFT  = 27;
	localparam int RECIP_W      = 17;
	localparam int QUOT_W       = 17;
	localparam int PROD_W       = NUM_W + RECIP_W;
	localparam int REM_W        = 28;

	localparam logic [7:0] START_BYTE = 8'h0f;

	localparam logic [CFG_IDX_W-1:0] CFG_ON_BELOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_ABOVE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK0_CTR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK1_CTR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK2_CTR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK3_CTR   = 3'd5;

	localparam logic [CHANNEL_BITS-1:0] RST_ON_BELOW  = 11'd500;
	localparam logic [CHANNEL_BITS-1:0] RST_OFF_ABOVE = 11'd1500;
	localparam logic [CHANNEL_BITS-1:0] RST_CENTER0   = 11'd1027;
	localparam logic [CHANNEL_BITS-1:0] RST_CENTER1   = 11'd1024;
	localparam logic [CHANNEL_BITS-1:0] RST_CENTER2   = 11'd1025;
	localparam logic [CHANNEL_BITS-1:0] RST_CENTER3   = 11'd1027;

	localparam logic [CHANNEL_BITS-1:0] STICK_SPAN [STICK_COUNT] = '{
		11'(1688 - 374), 11'(1680 - 368), 11'(1680 - 412), 11'(1673 - 360)
	};

	localparam logic [CHANNEL_BITS-1:0] STICK_HALF [STICK_COUNT] = '{
		11'((1688 - 374) / 2), 11'((1680 - 368) / 2),
		11'((1680 - 412) / 2), 11'((1673 - 360) / 2)
	};

	// floor(2^27 / span), estimate is low by at most one
	localparam logic [RECIP_W-1:0] STICK_RECIP [STICK_COUNT] = '{
		17'((1 << RECIP_SHIFT) / (1688 - 374)), 17'((1 << RECIP_SHIFT) / (1680 - 368)),
		17'((1 << RECIP_SHIFT) / (1680 - 412)), 17'((1 << RECIP_SHIFT) / (1673 - 360))
	};

	localparam logic signed [15:0] STICK_MAX = 16'sh7fff;
	localparam logic signed [15:0] STICK_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		KIND_PLAIN  = 2'd0,
		KIND_STICK  = 2'd1,
		KIND_SWITCH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SW_OFF     = 2'd0,
		SW_NEUTRAL = 2'd1,
		SW_ON      = 2'd2
	} sw_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0]                    on_below;
		logic [CHANNEL_BITS-1:0]                    off_above;
		logic [STICK_COUNT-1:0][CHANNEL_BITS-1:0]   center;
	} cfg_t;

	typedef struct packed {
		logic [CH_IDX_W-1:0]     ch;
		logic [CHANNEL_BITS-1:0] raw;
		kind_t                   kind;
		sw_t                     sw;
		logic                    neg;
		logic [CHANNEL_BITS-1:0] absd;
		logic [1:0]              sel;
		logic                    last;
	} chan_t;

endpackage

`default_nettype wire

// ===== src/sbus_frame_channel_decoder.sv =====
// sbus frame channel decoder
//
// rx channel (rx_valid, rx_stall, rx_byte): one received byte per request.
// bytes are dropped until the start byte 0x0f, then the following
// FRAME_BYTES-1 bytes form the frame; channels are unpacked lsb first.
// ch channel (ch_valid, ch_stall, fields): one request per completed
// channel, carrying raw value, kind, stick position (signed q1.15) and
// switch state; frame_last marks the final channel.
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always ready,
// writes switch thresholds and stick centers; unknown indexes are ignored.
// one byte is taken every cycle while rx_stall is low. the byte that completes a
// channel passes through the unpack register, the reciprocal multiply register
// and the correction/saturation output register.
// when ch_stall is high the output holds and the two inner stages fill,
// after which rx_stall rises; bubbles collapse so no cycle is lost.
// reset clears the frame state and loads the default thresholds/centers.
`default_nettype none

module sbus_frame_channel_decoder
	import sbfd_pkg::*;
#(
	parameter int FRAME_BYTES   = 25,
	parameter int CHANNEL_COUNT = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    rx_valid,
	output logic                         rx_stall,
	input  wire logic [7:0]              rx_byte,
	output logic                         ch_valid,
	input  wire logic                    ch_stall,
	output logic [CH_IDX_W-1:0]          channel_index,
	output logic [CHANNEL_BITS-1:0]      raw_value,
	output logic [1:0]                   channel_kind,
	output logic signed [15:0]           stick_value,
	output logic [1:0]                   switch_state,
	output logic                         frame_last,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CHANNEL_BITS-1:0] cfg_data
);

	cfg_t  cfg_q;
	chan_t stage1_item;
	logic  stage1_valid;
	logic  stage2_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_below  <= RST_ON_BELOW;
			cfg_q.off_above <= RST_OFF_ABOVE;
			cfg_q.center[0] <= RST_CENTER0;
			cfg_q.center[1] <= RST_CENTER1;
			cfg_q.center[2] <= RST_CENTER2;
			cfg_q.center[3] <= RST_CENTER3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ON_BELOW:   cfg_q.on_below  <= cfg_data;
				CFG_OFF_ABOVE:  cfg_q.off_above <= cfg_data;
				CFG_STICK0_CTR: cfg_q.center[0] <= cfg_data;
				CFG_STICK1_CTR: cfg_q.center[1] <= cfg_data;
				CFG_STICK2_CTR: cfg_q.center[2] <= cfg_data;
				CFG_STICK3_CTR: cfg_q.center[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sbfd_unpack #(
		.FRAME_BYTES   (FRAME_BYTES),
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.cfg        (cfg_q),
		.item       (stage1_item),
		.item_valid (stage1_valid),
		.item_ready (stage2_ready)
	);

	sbfd_norm u_norm (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (stage1_item),
		.item_valid    (stage1_valid),
		.item_ready    (stage2_ready),
		.ch_valid      (ch_valid),
		.ch_stall      (ch_stall),
		.channel_index (channel_index),
		.raw_value     (raw_value),
		.channel_kind  (channel_kind),
		.stick_value   (stick_value),
		.switch_state  (switch_state),
		.frame_last    (frame_last)
	);

	ap_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_valid && frame_last) |-> (channel_index == CH_IDX_W'(CHANNEL_COUNT - 1)))
		else $error("frame_last on a channel other than the final one");

endmodule

`default_nettype wire

// ===== src/sbfd_unpack.sv =====
`default_nettype none

module sbfd_unpack
	import sbfd_pkg::*;
#(
	parameter int FRAME_BYTES   = 25,
	parameter int CHANNEL_COUNT = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output chan_t           item,
	output logic            item_valid,
	input  wire logic       item_ready
);

	localparam int PosW = $clog2(FRAME_BYTES);
	localparam int ChW  = $clog2(CHANNEL_COUNT + 1);

	logic                    in_frame_q;
	logic [PosW-1:0]         pos_q;
	logic [ACC_W-1:0]        acc_q;
	logic [HELD_W-1:0]       held_q;
	logic [ChW-1:0]          nch_q;
	chan_t                   item_s1;
	logic                    valid_s1;

	logic                    advance;
	logic                    accept;
	logic                    data_ok;
	logic                    emit;
	logic [ACC_W-1:0]        acc_sum;
	logic [HELD_W-1:0]       held_sum;
	logic [CHANNEL_BITS:0]   diff;
	chan_t                   item_d;

	assign advance  = !valid_s1 || item_ready;
	assign rx_stall = !advance;
	assign accept   = rx_valid && advance;

	assign data_ok  = in_frame_q && (pos_q <= PosW'(DATA_LAST))
		&& (nch_q < ChW'(CHANNEL_COUNT));
	assign acc_sum  = acc_q | ACC_W'(26'(rx_byte) << held_q);
	assign held_sum = held_q + HELD_W'(8);
	assign emit     = data_ok && (held_sum >= HELD_W'(CHANNEL_BITS));

	always_comb begin
		item_d      = '0;
		item_d.ch   = nch_q[CH_IDX_W-1:0];
		item_d.raw  = acc_sum[CHANNEL_BITS-1:0];
		item_d.sel  = nch_q[1:0];
		item_d.last = (nch_q == ChW'(CHANNEL_COUNT - 1));
		item_d.kind = KIND_PLAIN;
		item_d.sw   = SW_OFF;
		diff = {1'b0, acc_sum[CHANNEL_BITS-1:0]} - {1'b0, cfg.center[nch_q[1:0]]};
		if (nch_q < ChW'(STICK_COUNT)) begin
			item_d.kind = KIND_STICK;
			item_d.neg  = diff[CHANNEL_BITS];
			item_d.absd = diff[CHANNEL_BITS] ? CHANNEL_BITS'(-diff)
				: diff[CHANNEL_BITS-1:0];
		end else if (nch_q < ChW'(SWITCH_FIRST + SWITCH_COUNT)) begin
			item_d.kind = KIND_SWITCH;
			priority if (item_d.raw < cfg.on_below) begin
				item_d.sw = SW_ON;
			end else if (item_d.raw > cfg.off_above) begin
				item_d.sw = SW_OFF;
			end else begin
				item_d.sw = SW_NEUTRAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			acc_q      <= '0;
			held_q     <= '0;
			nch_q      <= '0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (rx_byte == START_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= PosW'(1);
					acc_q      <= '0;
					held_q     <= '0;
					nch_q      <= '0;
				end
			end else begin
				if (data_ok) begin
					if (emit) begin
						acc_q  <= acc_sum >> CHANNEL_BITS;
						held_q <= held_sum - HELD_W'(CHANNEL_BITS);
						nch_q  <= nch_q + ChW'(1);
					end else begin
						acc_q  <= acc_sum;
						held_q <= held_sum;
					end
				end
				if (pos_q == PosW'(FRAME_BYTES - 1)) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end else begin
					pos_q <= pos_q + PosW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item_d;
		end
	end

	assign item       = item_s1;
	assign item_valid = valid_s1;

	ap_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(CHANNEL_BITS - 1))
		else $error("bit count exceeds one partial channel");

	ap_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (pos_q == '0))
		else $error("byte position nonzero outside a frame");

	ap_emit_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (valid_s1 && $past(in_frame_q)))
		else $error("channel produced outside a frame");

endmodule

`default_nettype wire

// ===== src/sbfd_norm.sv =====
`default_nettype none

module sbfd_norm
	import sbfd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire chan_t                   item,
	input  wire logic                    item_valid,
	output logic                         item_ready,
	output logic                         ch_valid,
	input  wire logic                    ch_stall,
	output logic [CH_IDX_W-1:0]          channel_index,
	output logic [CHANNEL_BITS-1:0]      raw_value,
	output logic [1:0]                   channel_kind,
	output logic signed [15:0]           stick_value,
	output logic [1:0]                   switch_state,
	output logic                         frame_last
);

	chan_t                   item_s2;
	logic [NUM_W-1:0]        num_s2;
	logic [QUOT_W-1:0]       q0_s2;
	logic                    valid_s2;
	chan_t                   item_s3;
	logic signed [15:0]      stick_s3;
	logic                    valid_s3;

	logic                    adv2;
	logic                    adv3;
	logic [NUM_W-1:0]        num;
	logic [PROD_W-1:0]       prod;
	logic [CHANNEL_BITS-1:0] span;
	logic [REM_W-1:0]        rem;
	logic [QUOT_W-1:0]       quot;
	logic signed [15:0]      stick_d;

	assign adv3       = !valid_s3 || !ch_stall;
	assign adv2       = !valid_s2 || adv3;
	assign item_ready = adv2;

	// numerator |d| * 2^15 + span/2, quotient estimate by reciprocal
	assign num  = {1'b0, item.absd, FRAC_BITS'(0)} + NUM_W'(STICK_HALF[item.sel]);
	assign prod = PROD_W'(num) * PROD_W'(STICK_RECIP[item.sel]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			item_s2 <= item;
			num_s2  <= num;
			q0_s2   <= prod[RECIP_SHIFT +: QUOT_W];
		end
	end

	// one correction step, then sign and saturate; non-stick channels give zero
	always_comb begin
		span = STICK_SPAN[item_s2.sel];
		rem  = REM_W'(num_s2) - REM_W'(q0_s2) * REM_W'(span);
		quot = q0_s2 + QUOT_W'(rem >= REM_W'(span));
		if (item_s2.kind != KIND_STICK) begin
			stick_d = '0;
		end else if (item_s2.neg) begin
			stick_d = (quot >= QUOT_W'(32768)) ? STICK_MIN : -$signed(quot[15:0]);
		end else begin
			stick_d = (quot >= QUOT_W'(32767)) ? STICK_MAX : $signed(quot[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			item_s3  <= item_s2;
			stick_s3 <= stick_d;
		end
	end

	assign ch_valid      = valid_s3;
	assign channel_index = item_s3.ch;
	assign raw_value     = item_s3.raw;
	assign channel_kind  = item_s3.kind;
	assign stick_value   = stick_s3;
	assign switch_state  = item_s3.sw;
	assign frame_last    = item_s3.last;

	ap_quot_close: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rem < (REM_W'(span) << 1)))
		else $error("reciprocal estimate off by more than one");

	ap_stick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_valid && (channel_kind != KIND_STICK)) |-> (stick_value == '0))
		else $error("stick value set on a non-stick channel");

	ap_switch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_valid && (channel_kind != KIND_SWITCH)) |-> (switch_state == SW_OFF))
		else $error("switch state set on a non-switch channel");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sbfd_pkg::*;

	localparam int FRAME_LEN    = 25;
	localparam int NUM_CHANNELS = 16;
	localparam int PHASES       = 9;
	localparam int PHASE_BYTES  = 158;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE       = 8;
	localparam int STICK_SPANS [STICK_COUNT] = '{1688 - 374, 1680 - 368, 1680 - 412, 1673 - 360};
	localparam logic [CHANNEL_BITS-1:0] RAW_MAX = 11'h7ff;

	typedef struct packed {
		logic [CH_IDX_W-1:0]     idx;
		logic [CHANNEL_BITS-1:0] raw;
		kind_t                   kind;
		logic signed [15:0]      stick;
		sw_t                     sw;
		logic                    last;
	} chan_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		chan_res_t  r;
	} stim_t;

	// idle noise, then one frame of all ones with every stick center at zero
	localparam stim_t FRAME_ROWS [29] = '{
		'{8'h00, 1'b0, '0},
		'{8'hff, 1'b0, '0},
		'{8'h0e, 1'b0, '0},
		'{8'h8f, 1'b0, '0},
		'{START_BYTE, 1'b0, '0},
		'{8'hff, 1'b0, '0},
		'{8'hff, 1'b1, '{4'd0, RAW_MAX, KIND_STICK, STICK_MAX, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd1, RAW_MAX, KIND_STICK, STICK_MAX, SW_OFF, 1'b0}},
		'{8'hff, 1'b0, '0},
		'{8'hff, 1'b1, '{4'd2, RAW_MAX, KIND_STICK, STICK_MAX, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd3, RAW_MAX, KIND_STICK, STICK_MAX, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd4, RAW_MAX, KIND_SWITCH, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b0, '0},
		'{8'hff, 1'b1, '{4'd5, RAW_MAX, KIND_SWITCH, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd6, RAW_MAX, KIND_SWITCH, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd7, RAW_MAX, KIND_SWITCH, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b0, '0},
		'{8'hff, 1'b1, '{4'd8, RAW_MAX, KIND_SWITCH, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd9, RAW_MAX, KIND_SWITCH, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b0, '0},
		'{8'hff, 1'b1, '{4'd10, RAW_MAX, KIND_PLAIN, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd11, RAW_MAX, KIND_PLAIN, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd12, RAW_MAX, KIND_PLAIN, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b0, '0},
		'{8'hff, 1'b1, '{4'd13, RAW_MAX, KIND_PLAIN, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd14, RAW_MAX, KIND_PLAIN, 16'sd0, SW_OFF, 1'b0}},
		'{8'hff, 1'b1, '{4'd15, RAW_MAX, KIND_PLAIN, 16'sd0, SW_OFF, 1'b1}},
		'{START_BYTE, 1'b0, '0},
		'{8'h00, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [7:0] rx_byte = '0;
	logic ch_valid;
	logic ch_stall = 1'b0;
	logic [CH_IDX_W-1:0] channel_index;
	logic [CHANNEL_BITS-1:0] raw_value;
	logic [1:0] channel_kind;
	logic signed [15:0] stick_value;
	logic [1:0] switch_state;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CHANNEL_BITS-1:0] cfg_data = '0;

	// predictor state and register copy
	logic [CHANNEL_BITS-1:0] sw_on_lim = RST_ON_BELOW;
	logic [CHANNEL_BITS-1:0] sw_off_lim = RST_OFF_ABOVE;
	logic [CHANNEL_BITS-1:0] stick_ctr [STICK_COUNT] =
		'{RST_CENTER0, RST_CENTER1, RST_CENTER2, RST_CENTER3};
	bit frm_open = 1'b0;
	int frm_pos = 0;
	logic [ACC_W-1:0] bit_buf = '0;
	int bit_cnt = 0;
	int chan_next = 0;

	stim_t byte_q [$];
	stim_t cur_stim;
	chan_res_t chan_q [$];
	int bytes_sent = 0;
	int bytes_taken = 0;
	int chans_checked = 0;
	int frames_done = 0;
	int settings = 0;
	int mism = 0;
	int rx_gap = 0;
	int st_left = 0;
	int quiet = 0;
	bit idle_on = 1'b1;

	sbus_frame_channel_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.ch_valid(ch_valid),
		.ch_stall(ch_stall),
		.channel_index(channel_index),
		.raw_value(raw_value),
		.channel_kind(channel_kind),
		.stick_value(stick_value),
		.switch_state(switch_state),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic signed [15:0] stick_pos(input logic [CHANNEL_BITS-1:0] raw,
			input int n);
		longint d, num, mag, q;
		d = longint'(raw) - longint'(stick_ctr[n]);
		num = d * 32768;
		mag = (num < 0) ? -num : num;
		q = (mag + STICK_SPANS[n] / 2) / STICK_SPANS[n];
		if (num < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return 16'(q);
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output chan_res_t c);
		bit got;
		got = 1'b0;
		c = '0;
		if (!frm_open) begin
			if (b == START_BYTE) begin
				frm_open = 1'b1;
				frm_pos = 1;
				bit_buf = '0;
				bit_cnt = 0;
				chan_next = 0;
			end
			return 1'b0;
		end
		if (frm_pos >= 1 && frm_pos <= DATA_LAST && chan_next < NUM_CHANNELS) begin
			bit_buf = ACC_W'(bit_buf | (32'(b) << bit_cnt));
			bit_cnt += 8;
			if (bit_cnt >= CHANNEL_BITS) begin
				c.idx = CH_IDX_W'(chan_next);
				c.raw = bit_buf[CHANNEL_BITS-1:0];
				c.kind = KIND_PLAIN;
				c.sw = SW_OFF;
				c.stick = '0;
				bit_buf = bit_buf >> CHANNEL_BITS;
				bit_cnt -= CHANNEL_BITS;
				if (chan_next < STICK_COUNT) begin
					c.kind = KIND_STICK;
					c.stick = stick_pos(c.raw, chan_next);
				end else if (chan_next >= SWITCH_FIRST &&
						chan_next < SWITCH_FIRST + SWITCH_COUNT) begin
					c.kind = KIND_SWITCH;
					if (c.raw < sw_on_lim)
						c.sw = SW_ON;
					else if (c.raw > sw_off_lim)
						c.sw = SW_OFF;
					else
						c.sw = SW_NEUTRAL;
				end
				c.last = (chan_next == NUM_CHANNELS - 1);
				chan_next++;
				got = 1'b1;
			end
		end
		frm_pos++;
		if (frm_pos >= FRAME_LEN) begin
			frm_open = 1'b0;
			frm_pos = 0;
		end
		return got;
	endfunction

	function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CHANNEL_BITS-1:0] v);
		case (idx)
			CFG_ON_BELOW:   sw_on_lim = v;
			CFG_OFF_ABOVE:  sw_off_lim = v;
			CFG_STICK0_CTR: stick_ctr[0] = v;
			CFG_STICK1_CTR: stick_ctr[1] = v;
			CFG_STICK2_CTR: stick_ctr[2] = v;
			CFG_STICK3_CTR: stick_ctr[3] = v;
			default: ;
		endcase
	endfunction

	task automatic field_chk(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			mism++;
		end
	endtask

	// writes every index; the two unused ones get junk that must not land anywhere
	task automatic program_regs(input logic [CHANNEL_BITS-1:0] on_lim, off_lim,
			c0, c1, c2, c3);
		logic [CHANNEL_BITS-1:0] vals [1 << CFG_IDX_W];
		vals[CFG_ON_BELOW] = on_lim;
		vals[CFG_OFF_ABOVE] = off_lim;
		vals[CFG_STICK0_CTR] = c0;
		vals[CFG_STICK1_CTR] = c1;
		vals[CFG_STICK2_CTR] = c2;
		vals[CFG_STICK3_CTR] = c3;
		vals[CFG_STICK3_CTR + 3'd1] = CHANNEL_BITS'($urandom);
		vals[CFG_STICK3_CTR + 3'd2] = CHANNEL_BITS'($urandom);
		for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			set_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		stim_t s;
		s = '0;
		s.b = b;
		byte_q.push_back(s);
		bytes_sent++;
	endtask

	// one frame with random channel content, sometimes cut short, with a stray start byte or with trailing junk bytes
	task automatic add_frame();
		logic [16*CHANNEL_BITS-1:0] bits;
		int mode, cut, v;
		logic [7:0] b;
		mode = $urandom_range(0, 3);
		for (int n = 0; n < 16; n++) begin
			case (mode)
				1: begin
					case ($urandom_range(0, 3))
						0: v = 0;
						1: v = 1;
						2: v = 2046;
						default: v = 2047;
					endcase
				end
				2: begin
					if (n < STICK_COUNT)
						v = int'(stick_ctr[n]) + int'($urandom_range(0, 80)) - 40;
					else if (n < SWITCH_FIRST + SWITCH_COUNT)
						v = ($urandom_range(0, 1) ? int'(sw_on_lim) : int'(sw_off_lim)) +
							int'($urandom_range(0, 4)) - 2;
					else
						v = $urandom_range(0, 2047);
				end
				default: v = $urandom_range(0, 2047);
			endcase
			v = (v < 0) ? 0 : ((v > 2047) ? 2047 : v);
			bits[n*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(v);
		end
		if (mode == 3) begin
			for (int k = 0; k < DATA_LAST; k++)
				bits[k*8 +: 8] = 8'($urandom);
		end
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_LEN - 2) : FRAME_LEN - 1;
		push_byte(START_BYTE);
		for (int k = 1; k <= cut; k++) begin
			if (k <= DATA_LAST)
				b = bits[(k-1)*8 +: 8];
			else if (k == DATA_LAST + 1)
				b = 8'($urandom);
			else
				b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
			if ($urandom_range(0, 39) == 0)
				b = START_BYTE;
			push_byte(b);
		end
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
		end
	endtask

	task automatic drain();
		while (!(bytes_taken == bytes_sent && chan_q.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// request side
	always @(posedge clk) begin
		chan_res_t pr;
		bit got;
		if (rx_valid && !rx_stall) begin
			got = decode_byte(rx_byte, pr);
			if (cur_stim.typed)
				chan_q.push_back(cur_stim.r);
			else if (got)
				chan_q.push_back(pr);
			bytes_taken++;
		end
		if (!rx_valid || !rx_stall) begin
			if (rx_gap > 0) begin
				rx_gap--;
				rx_valid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				cur_stim = byte_q.pop_front();
				rx_byte <= cur_stim.b;
				rx_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 11) == 0)
					rx_gap = $urandom_range(1, 14);
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// channel side
	always @(posedge clk) begin
		chan_res_t w;
		if (ch_valid && !ch_stall) begin
			if (chan_q.size() == 0) begin
				$error("channel %0d arrived with none predicted", channel_index);
				mism++;
			end else begin
				w = chan_q.pop_front();
				field_chk("channel_index", w.idx, channel_index);
				field_chk("raw_value", w.raw, raw_value);
				field_chk("channel_kind", w.kind, channel_kind);
				field_chk("stick_value", $signed(w.stick), stick_value);
				field_chk("switch_state", w.sw, switch_state);
				field_chk("frame_last", w.last, frame_last);
				chans_checked++;
				if (w.last)
					frames_done++;
			end
		end
		if (st_left > 0) begin
			st_left--;
			ch_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			st_left = $urandom_range(0, 13);
			ch_stall <= 1'b1;
		end else begin
			ch_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((rx_valid && !rx_stall) || (ch_valid && !ch_stall) || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL sbus_frame_channel_decoder");
				$finish;
			end
		end
	end

	initial begin
		logic [CHANNEL_BITS-1:0] a, z, t;
		int goal;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(RST_ON_BELOW, RST_OFF_ABOVE, '0, '0, '0, '0);
		foreach (FRAME_ROWS[i]) begin
			byte_q.push_back(FRAME_ROWS[i]);
			bytes_sent++;
		end
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_regs(RST_ON_BELOW, RST_OFF_ABOVE, RST_CENTER0, RST_CENTER1,
					RST_CENTER2, RST_CENTER3);
				1: program_regs('0, '0, '0, '0, '0, '0);
				2: program_regs(RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX);
				3: program_regs(RST_OFF_ABOVE, RST_ON_BELOW, CHANNEL_BITS'($urandom),
					CHANNEL_BITS'($urandom), CHANNEL_BITS'($urandom),
					CHANNEL_BITS'($urandom));
				default: begin
					a = CHANNEL_BITS'($urandom);
					z = CHANNEL_BITS'($urandom);
					if (a > z && $urandom_range(0, 3) != 0) begin
						t = a;
						a = z;
						z = t;
					end
					program_regs(a, z, CHANNEL_BITS'($urandom), CHANNEL_BITS'($urandom),
						CHANNEL_BITS'($urandom), CHANNEL_BITS'($urandom));
				end
			endcase
			idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			goal = bytes_sent + PHASE_BYTES;
			while (bytes_sent < goal)
				add_frame();
			drain();
		end

		$display("decoded %0d bytes under %0d register settings", bytes_taken, settings);
		$display("checked %0d channels, %0d full frames", chans_checked, frames_done);
		if (mism == 0)
			$display("PASS sbus_frame_channel_decoder");
		else
			$display("FAIL sbus_frame_channel_decoder");
		$finish;
	end

endmodule
